>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the compensation block
// Shared property forms; every use names aclk and aresetn of its module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, scale table and control struct of the compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W   = 24;
    localparam int SC_W    = 31;   // signed Q24 scaled sample
    localparam int DIVR_W  = 23;   // scale factor width
    localparam int DIV_W   = 48;   // dividend bits, one per cycle
    localparam int QUOT_W  = 30;
    localparam int OPA_W   = 64;
    localparam int OPB_W   = 32;
    localparam int MUL_CYC = 32;
    localparam int CFG_W   = 40;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_TCOEF = 3'd0;
    localparam logic [IDX_W-1:0] REG_POFLN = 3'd1;
    localparam logic [IDX_W-1:0] REG_PCROS = 3'd2;
    localparam logic [IDX_W-1:0] REG_PHIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_PCUBE = 3'd4;
    localparam logic [IDX_W-1:0] REG_TRATE = 3'd5;
    localparam logic [IDX_W-1:0] REG_PRATE = 3'd6;

    localparam logic signed [OPB_W-1:0] MILLI = 32'sd1000;

    // multiplier request
    typedef struct packed {
        logic start;
        logic shift;   // drop 24 fraction bits of the product
    } mul_req_t;

    // oversampling scale factors
    function automatic logic [DIVR_W-1:0] scale_factor(input logic [IDX_W-1:0] idx);
        logic [DIVR_W-1:0] f;
        case (idx)
            3'd0:    f = 23'd524288;
            3'd1:    f = 23'd1572864;
            3'd2:    f = 23'd3670016;
            3'd3:    f = 23'd7864320;
            3'd4:    f = 23'd253952;
            3'd5:    f = 23'd516096;
            3'd6:    f = 23'd1040384;
            default: f = 23'd2088960;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptc_pkg::RAW_W-1:0]     mag,
    input  logic [ptc_pkg::DIVR_W-1:0]    divisor,
    output logic                          done,
    output logic [ptc_pkg::QUOT_W-1:0]    quot
);

    logic [ptc_pkg::DIV_W-1:0]  dq_reg;
    logic [ptc_pkg::DIVR_W-1:0] rem_reg, d_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic [ptc_pkg::DIVR_W:0]   trial, diff;
    logic                       ge;

    // trial subtract
    assign trial = {rem_reg, dq_reg[ptc_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dq_reg   <= {mag, {(ptc_pkg::DIV_W-ptc_pkg::RAW_W){1'b0}}};
                rem_reg  <= '0;
                d_reg    <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dq_reg  <= {dq_reg[ptc_pkg::DIV_W-2:0], ge};
                rem_reg <= ge ? diff[ptc_pkg::DIVR_W-1:0] : trial[ptc_pkg::DIVR_W-1:0];
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(ptc_pkg::DIV_W-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = dq_reg[ptc_pkg::QUOT_W-1:0];

endmodule

>>> rtl/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul
// Sign-magnitude shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ptc_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ptc_pkg::mul_req_t                 req,
    input  logic signed [ptc_pkg::OPA_W-1:0]  op_a,
    input  logic signed [ptc_pkg::OPB_W-1:0]  op_b,
    output logic                              done,
    output logic signed [ptc_pkg::OPA_W-1:0]  prod
);

    localparam int ACC_W = ptc_pkg::OPA_W + ptc_pkg::OPB_W;

    logic [ACC_W-1:0]         acc_reg;
    logic [ptc_pkg::OPA_W-1:0] ma_reg;
    logic [ptc_pkg::OPB_W-1:0] mb_reg;
    logic [4:0]               cnt_reg;
    logic                     busy_reg, done_reg, neg_reg, shift_reg;
    logic [ptc_pkg::OPA_W:0]  sum;
    logic [ptc_pkg::OPA_W-1:0] mag;

    // add multiplicand at the top, shift right
    assign sum = {1'b0, acc_reg[ACC_W-1:ptc_pkg::OPB_W]}
               + {1'b0, (mb_reg[0] ? ma_reg : {ptc_pkg::OPA_W{1'b0}})};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                ma_reg    <= op_a[ptc_pkg::OPA_W-1] ? 64'(-op_a) : 64'(op_a);
                mb_reg    <= op_b[ptc_pkg::OPB_W-1] ? 32'(-op_b) : 32'(op_b);
                neg_reg   <= op_a[ptc_pkg::OPA_W-1] ^ op_b[ptc_pkg::OPB_W-1];
                shift_reg <= req.shift;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= {sum, acc_reg[ptc_pkg::OPB_W-1:1]};
                mb_reg  <= {1'b0, mb_reg[ptc_pkg::OPB_W-1:1]};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ptc_pkg::MUL_CYC-1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // truncate magnitude, then restore sign
    assign mag  = shift_reg ? acc_reg[ptc_pkg::OPA_W+23:24] : acc_reg[ptc_pkg::OPA_W-1:0];
    assign prod = neg_reg ? -$signed(mag) : $signed(mag);
    assign done = done_reg;

endmodule

>>> rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric polynomial compensation with a bit-serial divider and multiplier.
//
//   channel  | dir | handshake          | words
//   s_       | in  | s_valid / s_ready  | s_op, s_raw_sample
//   m_       | out | m_valid / m_ready  | m_kind, m_value_milli
//   cfg_     | in  | cfg_wen            | cfg_index, cfg_wdata
//
// Scaling runs the sample through the divider and a hand-over; each product
// runs in the shared multiplier, started from ST_MGO and then handed over.
// The output cycle follows. One word at a time; s_ready is high when the
// sequencer is idle, even while a finished result waits in the output register.
// A held result that is not taken stalls the sequencer in its output cycle.
// Synchronous active-low reset clears control state and the stored temperature.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pressure_temperature_compensation (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic signed [ptc_pkg::RAW_W-1:0]  s_raw_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic signed [31:0]                m_value_milli,
    input  logic                              cfg_wen,
    input  logic [ptc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MGO  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [2:0] SP_C30  = 3'd0;
    localparam logic [2:0] SP_A1   = 3'd1;
    localparam logic [2:0] SP_A2   = 3'd2;
    localparam logic [2:0] SP_C21  = 3'd3;
    localparam logic [2:0] SP_B1   = 3'd4;
    localparam logic [2:0] SP_BT   = 3'd5;
    localparam logic [2:0] SP_MIL  = 3'd6;
    localparam logic [2:0] SP_TMP  = 3'd7;

    logic [23:0] tcoef_reg;
    logic [39:0] pofln_reg;
    logic [31:0] pcros_reg, phigh_reg;
    logic [15:0] pcube_reg;
    logic [2:0]  trate_reg, prate_reg;

    logic [2:0]  state_reg, step_reg;
    logic        op_reg, div_start;
    logic [ptc_pkg::RAW_W-1:0] mag_reg;
    logic        neg_reg;
    logic signed [ptc_pkg::SC_W-1:0] sc_reg, st_reg;
    logic signed [63:0] acc_reg, bac_reg, res_reg;
    logic        m_valid_reg, m_kind_reg;
    logic signed [31:0] m_val_reg;

    logic        div_done, mul_done;
    logic [ptc_pkg::QUOT_W-1:0] quot;
    logic signed [ptc_pkg::SC_W-1:0] sc_next;
    ptc_pkg::mul_req_t mreq;
    logic signed [63:0] op_a, prod, addend, total;
    logic signed [31:0] op_b, sat;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcoef_reg <= '0; pofln_reg <= '0; pcros_reg <= '0; phigh_reg <= '0;
            pcube_reg <= '0; trate_reg <= '0; prate_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                ptc_pkg::REG_TCOEF: tcoef_reg <= cfg_wdata[23:0];
                ptc_pkg::REG_POFLN: pofln_reg <= cfg_wdata;
                ptc_pkg::REG_PCROS: pcros_reg <= cfg_wdata[31:0];
                ptc_pkg::REG_PHIGH: phigh_reg <= cfg_wdata[31:0];
                ptc_pkg::REG_PCUBE: pcube_reg <= cfg_wdata[15:0];
                ptc_pkg::REG_TRATE: trate_reg <= cfg_wdata[2:0];
                ptc_pkg::REG_PRATE: prate_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign div_start = (state_reg == ST_IDLE) && s_valid;

    ptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (s_raw_sample[ptc_pkg::RAW_W-1] ? 24'(-s_raw_sample) : 24'(s_raw_sample)),
        .divisor (ptc_pkg::scale_factor(s_op ? prate_reg : trate_reg)),
        .done    (div_done),
        .quot    (quot)
    );

    assign sc_next = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    // operand and addend selection per step
    always_comb begin
        op_a   = acc_reg;
        op_b   = 32'(sc_reg);
        addend = '0;
        mreq.shift = 1'b1;
        case (step_reg)
            SP_C30: begin
                op_a = 64'(signed'(pcube_reg)); mreq.shift = 1'b0;
                addend = {{24{phigh_reg[31]}}, phigh_reg[31:16], 24'd0};
            end
            SP_A1:  addend = {{24{pofln_reg[19]}}, pofln_reg[19:0], 20'd0} <<< 4;
            SP_A2:  addend = {{20{pofln_reg[39]}}, pofln_reg[39:20], 24'd0};
            SP_C21: begin
                op_a = 64'(signed'(phigh_reg[15:0])); mreq.shift = 1'b0;
                addend = {{24{pcros_reg[15]}}, pcros_reg[15:0], 24'd0};
            end
            SP_B1:  begin
                op_a = bac_reg;
                addend = {{24{pcros_reg[31]}}, pcros_reg[31:16], 24'd0};
            end
            SP_BT:  begin
                op_a = bac_reg; op_b = 32'(st_reg); addend = acc_reg;
            end
            SP_MIL: op_b = ptc_pkg::MILLI;
            default: begin
                op_a = 64'(signed'(tcoef_reg[11:0])); mreq.shift = 1'b0;
                addend = {{29{tcoef_reg[23]}}, tcoef_reg[23:12], 23'd0};
            end
        endcase
        mreq.start = (state_reg == ST_MGO);
    end

    ptc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .prod    (prod)
    );

    assign total = prod + addend;

    // saturate to 32 bits
    assign sat = (res_reg > 64'sd2147483647)  ? 32'sh7fffffff :
                 (res_reg < -64'sd2147483648) ? 32'sh80000000 : res_reg[31:0];

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= SP_TMP;
            st_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // output word taken; the output cycle reloads it itself
            if (m_valid_reg && m_ready && state_reg != ST_FIN) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    op_reg    <= s_op;
                    neg_reg   <= s_raw_sample[ptc_pkg::RAW_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV: if (div_done) begin
                    sc_reg <= sc_next;
                    if (!op_reg) st_reg <= sc_next;
                    step_reg  <= op_reg ? SP_C30 : SP_TMP;
                    state_reg <= ST_MGO;
                end
                ST_MGO: state_reg <= ST_MUL;
                ST_MUL: if (mul_done) begin
                    case (step_reg)
                        SP_C21, SP_B1: bac_reg <= total;
                        SP_MIL:        res_reg <= prod;
                        default:       acc_reg <= total;
                    endcase
                    if (step_reg == SP_MIL) begin
                        state_reg <= ST_FIN;
                    end else begin
                        step_reg  <= (step_reg == SP_TMP) ? SP_MIL : step_reg + 3'd1;
                        state_reg <= ST_MGO;
                    end
                end
                ST_FIN: if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                    m_kind_reg  <= op_reg;
                    m_val_reg   <= sat;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_value_milli = m_val_reg;

    `PTC_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `PTC_ASSERT_IMP(a_mul_done_in_mul, mul_done, state_reg == ST_MUL)
    `PTC_ASSERT_NXT(a_accept_starts_div, s_valid && s_ready, state_reg == ST_DIV)

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pressure_temperature_compensation. It starts with a
// table of directed samples, then runs random phases under several coefficient
// and oversampling settings and several idling patterns. Every result word is
// checked against a fixed-point predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRS  = 1'b1;
    localparam logic [ptc_pkg::IDX_W-1:0] REG_NONE = 3'd7;   // unmapped index, write is dropped

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 50;
    localparam int DRAIN_CYC  = 400;

    typedef enum logic [1:0] {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic        kind;
        logic [31:0] value;
    } comp_result_t;

    // directed row: new_cfg 0 keeps settings, 1 loads the positive extremes,
    // 2 loads the negative extremes
    typedef struct {
        int                               new_cfg;
        logic                             op;
        logic signed [ptc_pkg::RAW_W-1:0] raw;
        bit                               known;
        logic [31:0]                      value;
    } sample_row_t;

    localparam longint OSR_SCALE [8] = '{
        524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
    };

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_op = 1'b0;
    logic signed [ptc_pkg::RAW_W-1:0] s_raw_sample = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic                             m_kind;
    logic signed [31:0]               m_value_milli;
    logic                             cfg_wen = 1'b0;
    logic [ptc_pkg::IDX_W-1:0]        cfg_index = '0;
    logic [ptc_pkg::CFG_W-1:0]        cfg_wdata = '0;

    // predictor state
    logic [23:0] coef_t;
    logic [39:0] coef_p_lin;
    logic [31:0] coef_p_cross;
    logic [31:0] coef_p_high;
    logic [15:0] coef_p_cube;
    logic [2:0]  rate_t;
    logic [2:0]  rate_p;
    longint      held_temp;

    comp_result_t pending_results[$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int           fail_count = 0;

    pressure_temperature_compensation dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // (a * b) >> 24, truncated toward zero
    function automatic longint mul_frac(longint a, longint b);
        logic [127:0] ua, ub, p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = 128'(a < 0 ? -a : a);
        ub  = 128'(b < 0 ? -b : b);
        p   = (ua * ub) >> 24;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // raw sample to Q24 by the oversampling scale factor
    function automatic longint scale_sample(logic signed [ptc_pkg::RAW_W-1:0] raw,
                                            logic [2:0] idx);
        longint s, q;
        s = longint'(raw);
        q = ((s < 0 ? -s : s) << 24) / OSR_SCALE[idx];
        return s < 0 ? -q : q;
    endfunction

    // compensated value in thousandths, updating the held temperature
    function automatic logic [31:0] compensate(logic op,
                                               logic signed [ptc_pkg::RAW_W-1:0] raw);
        longint one, v, m, sp, a, b;
        one = longint'(1) << 24;
        if (op == OP_TEMP) begin
            held_temp = scale_sample(raw, rate_t);
            v = longint'($signed(coef_t[23:12])) * (longint'(1) << 23)
              + longint'($signed(coef_t[11:0])) * held_temp;
        end else begin
            sp = scale_sample(raw, rate_p);
            a = longint'($signed(coef_p_high[31:16])) * one
              + longint'($signed(coef_p_cube)) * sp;
            a = longint'($signed(coef_p_lin[19:0])) * one + mul_frac(a, sp);
            a = longint'($signed(coef_p_lin[39:20])) * one + mul_frac(a, sp);
            b = longint'($signed(coef_p_cross[15:0])) * one
              + longint'($signed(coef_p_high[15:0])) * sp;
            b = longint'($signed(coef_p_cross[31:16])) * one + mul_frac(b, sp);
            v = a + mul_frac(b, held_temp);
        end
        m = mul_frac(v, 1000);
        if (m > 64'sd2147483647)  m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        return m[31:0];
    endfunction

    // one register write, mirrored into the predictor
    task automatic write_reg(logic [ptc_pkg::IDX_W-1:0] idx, logic [ptc_pkg::CFG_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            ptc_pkg::REG_TCOEF: coef_t       = data[23:0];
            ptc_pkg::REG_POFLN: coef_p_lin   = data[39:0];
            ptc_pkg::REG_PCROS: coef_p_cross = data[31:0];
            ptc_pkg::REG_PHIGH: coef_p_high  = data[31:0];
            ptc_pkg::REG_PCUBE: coef_p_cube  = data[15:0];
            ptc_pkg::REG_TRATE: rate_t       = data[2:0];
            ptc_pkg::REG_PRATE: rate_p       = data[2:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // wait for every result, then let the sequencer settle
    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // offer one word, predict on acceptance
    task automatic send_word(logic op, logic signed [ptc_pkg::RAW_W-1:0] raw,
                             bit known, logic [31:0] value);
        comp_result_t r;
        int           gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 65 : (idle_mode == IDLE_BOTH) ? 24 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_raw_sample <= raw;
        do @(posedge aclk); while (!s_ready);
        r.kind  = op;
        r.value = compensate(op, raw);
        if (known && r.value !== value) begin
            $error("directed value_milli: table %0d predictor %0d",
                   $signed(value), $signed(r.value));
            fail_count++;
        end
        pending_results.push_back(r);
        @(negedge aclk);
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= $urandom_range(99) >= 65;
            IDLE_BOTH:     m_ready <= $urandom_range(99) >= 24;
            default:       m_ready <= 1'b1;
        endcase
    end

    // result check
    always @(posedge aclk) begin
        comp_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: kind %0d value_milli %0d",
                       m_kind, m_value_milli);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (m_kind !== e.kind) begin
                    $error("kind: expected %0d actual %0d", e.kind, m_kind);
                    fail_count++;
                end
                if (m_value_milli !== e.value) begin
                    $error("value_milli: expected %0d actual %0d",
                           $signed(e.value), m_value_milli);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        sample_row_t rows[$];
        logic signed [ptc_pkg::RAW_W-1:0] raw;
        logic [ptc_pkg::CFG_W-1:0] rnd;
        int pick;

        coef_t = '0; coef_p_lin = '0; coef_p_cross = '0; coef_p_high = '0;
        coef_p_cube = '0; rate_t = '0; rate_p = '0; held_temp = 0;

        // reset settings give zero everywhere, pressure first with no temperature held
        rows = '{
            '{0, OP_PRS,  24'sh7FFFFF, 1, 32'd0},
            '{0, OP_TEMP, 24'sh800000, 1, 32'd0},
            '{0, OP_TEMP, 24'sh7FFFFF, 1, 32'd0},
            '{0, OP_PRS,  24'sh000000, 1, 32'd0},
            '{0, OP_PRS,  24'sh800000, 1, 32'd0},
            '{1, OP_PRS,  24'sh7FFFFF, 0, 32'd0},
            '{0, OP_TEMP, 24'sh000000, 0, 32'd0},
            '{0, OP_TEMP, 24'sh7FFFFF, 0, 32'd0},
            '{0, OP_PRS,  24'sh7FFFFF, 0, 32'd0},
            '{0, OP_PRS,  24'sh800000, 0, 32'd0},
            '{0, OP_TEMP, 24'sh800000, 0, 32'd0},
            '{0, OP_PRS,  24'sh000001, 0, 32'd0},
            '{0, OP_PRS,  24'shFFFFFF, 0, 32'd0},
            '{2, OP_TEMP, 24'sh7FFFFF, 0, 32'd0},
            '{0, OP_PRS,  24'sh7FFFFF, 0, 32'd0},
            '{0, OP_PRS,  24'sh800000, 0, 32'd0},
            '{0, OP_TEMP, 24'sh800000, 0, 32'd0},
            '{0, OP_PRS,  24'sh7FFFFF, 0, 32'd0},
            '{0, OP_PRS,  24'sh000000, 0, 32'd0}
        };

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (rows[i]) begin
            if (rows[i].new_cfg != 0) begin
                s_valid <= 1'b0;
                drain();
                if (rows[i].new_cfg == 1) begin
                    write_reg(ptc_pkg::REG_TCOEF, '1);            // upper bits dropped
                    write_reg(ptc_pkg::REG_TCOEF, 40'h7FF7FF);
                    write_reg(ptc_pkg::REG_POFLN, 40'h7FFFF7FFFF);
                    write_reg(ptc_pkg::REG_PCROS, 40'h7FFF7FFF);
                    write_reg(ptc_pkg::REG_PHIGH, 40'h7FFF7FFF);
                    write_reg(ptc_pkg::REG_PCUBE, 40'h7FFF);
                    write_reg(ptc_pkg::REG_TRATE, 40'd4);
                    write_reg(ptc_pkg::REG_PRATE, 40'd4);
                    write_reg(REG_NONE,  '1);                      // ignored
                end else begin
                    write_reg(ptc_pkg::REG_TCOEF, 40'h800800);
                    write_reg(ptc_pkg::REG_POFLN, 40'h8000080000);
                    write_reg(ptc_pkg::REG_PCROS, 40'h80008000);
                    write_reg(ptc_pkg::REG_PHIGH, 40'h80008000);
                    write_reg(ptc_pkg::REG_PCUBE, 40'h8000);
                    write_reg(ptc_pkg::REG_TRATE, 40'd7);
                    write_reg(ptc_pkg::REG_PRATE, 40'd7);
                end
                cfg_wen <= 1'b0;
            end
            send_word(rows[i].op, rows[i].raw, rows[i].known, rows[i].value);
        end

        // random phases; the drain between phases holds the sender until all results are in
        for (int ph = 0; ph < PHASES; ph++) begin
            s_valid <= 1'b0;
            drain();
            idle_mode = idle_mode_t'(ph % 4);
            rnd = {$urandom, $urandom};
            write_reg(ptc_pkg::REG_TCOEF, rnd);
            rnd = {$urandom, $urandom};
            write_reg(ptc_pkg::REG_POFLN, rnd);
            write_reg(ptc_pkg::REG_PCROS, {8'h00, $urandom});
            write_reg(ptc_pkg::REG_PHIGH, {8'h00, $urandom});
            write_reg(ptc_pkg::REG_PCUBE, {24'h0, 16'($urandom)});
            write_reg(ptc_pkg::REG_TRATE,
                      ph == 1 ? 40'd0 : ph == 2 ? 40'd7 : 40'($urandom_range(7)));
            write_reg(ptc_pkg::REG_PRATE,
                      ph == 1 ? 40'd7 : ph == 2 ? 40'd0 : 40'($urandom_range(7)));
            cfg_wen <= 1'b0;
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(9);
                case (pick)
                    0:       raw = 24'sh7FFFFF;
                    1:       raw = 24'sh800000;
                    2:       raw = ptc_pkg::RAW_W'($signed($urandom_range(511)) - 256);
                    default: raw = ptc_pkg::RAW_W'($urandom);
                endcase
                send_word(1'($urandom), raw, 0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
